/* design/utf8sd_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
package utf8sd_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // Sequence lengths held in seq_length
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  // Results caused by one byte: rep_cnt replacements, then an optional tail.
  typedef struct packed {
    logic [1:0]      rep_cnt;
    logic            has_tail;
    logic [CP_W-1:0] tail;
  } job_t;

endpackage

/* design/utf8sd_decode.sv */
// Sequence state and per-byte decode for the UTF-8 stream decoder.
// Depends on utf8sd_pkg. Produces one job_t per accepted byte.
module utf8sd_decode
  import utf8sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_byte,
  output job_t       job,
  output logic       job_nonempty
);

  logic [2:0]      seq_length, seq_length_next;
  logic [1:0]      bytes_held, bytes_held_next;
  logic [CP_W-1:0] partial_code, partial_code_next;

  logic            open_seq;
  logic            is_cont;
  logic [2:0]      held_inc;
  logic [CP_W-1:0] code_shift;

  assign open_seq   = (seq_length != SEQ_NONE);
  assign is_cont    = (in_byte[7:6] == 2'b10);
  assign held_inc   = {1'b0, bytes_held} + 3'd1;
  assign code_shift = {partial_code[CP_W-7:0], in_byte[5:0]};

  always_comb begin
    seq_length_next   = seq_length;
    bytes_held_next   = bytes_held;
    partial_code_next = partial_code;
    job.rep_cnt  = 2'd0;
    job.has_tail = 1'b0;
    job.tail     = REPLACEMENT_CP;

    if (open_seq && is_cont) begin
      if (held_inc >= seq_length) begin
        job.has_tail      = 1'b1;
        job.tail          = code_shift;
        seq_length_next   = SEQ_NONE;
        bytes_held_next   = 2'd0;
        partial_code_next = '0;
      end else begin
        bytes_held_next   = held_inc[1:0];
        partial_code_next = code_shift;
      end
    end else begin
      // a broken sequence flushes one replacement per held byte
      job.rep_cnt       = open_seq ? bytes_held : 2'd0;
      seq_length_next   = SEQ_NONE;
      bytes_held_next   = 2'd0;
      partial_code_next = '0;
      if (in_byte == 8'h00) begin
        job.has_tail = 1'b0;
      end else if (in_byte[7] == 1'b0) begin
        job.has_tail = 1'b1;
        job.tail     = {{(CP_W-8){1'b0}}, in_byte};
      end else if (in_byte[7:5] == 3'b110) begin
        seq_length_next   = SEQ_TWO;
        bytes_held_next   = 2'd1;
        partial_code_next = {{(CP_W-5){1'b0}}, in_byte[4:0]};
      end else if (in_byte[7:4] == 4'b1110) begin
        seq_length_next   = SEQ_THREE;
        bytes_held_next   = 2'd1;
        partial_code_next = {{(CP_W-4){1'b0}}, in_byte[3:0]};
      end else if (in_byte[7:3] == 5'b11110) begin
        seq_length_next   = SEQ_FOUR;
        bytes_held_next   = 2'd1;
        partial_code_next = {{(CP_W-3){1'b0}}, in_byte[2:0]};
      end else begin
        job.has_tail = 1'b1;
        job.tail     = REPLACEMENT_CP;
      end
    end
  end

  assign job_nonempty = job.has_tail || (job.rep_cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length   <= SEQ_NONE;
      bytes_held   <= 2'd0;
      partial_code <= '0;
    end else if (take) begin
      seq_length   <= seq_length_next;
      bytes_held   <= bytes_held_next;
      partial_code <= partial_code_next;
    end
  end

endmodule

/* design/utf8sd_seq.sv */
// Two-slot result queue that expands each job into code point results.
// Depends on utf8sd_pkg. Input ready comes straight from a register.
module utf8sd_seq
  import utf8sd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  job_t            push_job,
  output logic            space,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] code_point,
  output logic            last_of_run
);

  logic cur_valid, pend_valid;
  job_t cur, pend;
  logic fire, fire_last, cur_free;

  assign out_valid   = cur_valid;
  assign code_point  = (cur.rep_cnt != 2'd0) ? REPLACEMENT_CP : cur.tail;
  assign last_of_run = (cur.rep_cnt == 2'd0) ||
                       ((cur.rep_cnt == 2'd1) && !cur.has_tail);
  assign fire        = cur_valid && out_ready;
  assign fire_last   = fire && last_of_run;
  assign cur_free    = !cur_valid || fire_last;
  assign space       = !pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (cur_free) begin
      if (pend_valid) begin
        cur_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        cur_valid <= push;
      end
    end else if (push) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_free) begin
      if (pend_valid) begin
        cur <= pend;
      end else if (push) begin
        cur <= push_job;
      end
    end else begin
      if (fire) begin
        cur.rep_cnt <= cur.rep_cnt - 2'd1;
      end
      if (push) begin
        pend <= push_job;
      end
    end
  end

endmodule

/* design/utf8_stream_decoder.sv */
// Lenient UTF-8 decoder: one text byte in per request, zero to four code points
// out, one per ready cycle. A byte is taken every cycle while the output keeps
// up; only error flushes (up to three replacements plus one more result for the
// breaking byte) occupy the output for extra cycles, and a two-slot result
// queue keeps input ready registered. No overlong, surrogate or range checks;
// broken sequences give one U+FFFD per held byte, byte 0 ends the text.
// Depends on utf8sd_pkg, utf8sd_decode and utf8sd_seq.
module utf8_stream_decoder
  import utf8sd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] code_point,
  output logic            last_of_run
);

  logic take;
  job_t job;
  logic job_nonempty;

  assign take = in_valid && in_ready;

  utf8sd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .in_byte      (in_byte),
    .job          (job),
    .job_nonempty (job_nonempty)
  );

  utf8sd_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .push        (take && job_nonempty),
    .push_job    (job),
    .space       (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .last_of_run (last_of_run)
  );

endmodule

/* tb/sv/utf8sd_checker.sv */
// Checker for utf8_stream_decoder: watches both request channels, predicts the code points.
// Each result is compared against the oldest prediction. Depends on utf8sd_pkg.
`timescale 1ns / 100ps
module utf8sd_checker
  import utf8sd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic [CP_W-1:0] code_point,
  input  logic            last_of_run,
  output int              mismatches,
  output int              awaited
);

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            last;
  } cp_item_t;

  cp_item_t        cp_expected_q[$];
  cp_item_t        want;

  // Decoder state as predicted
  logic [2:0]      open_len;
  logic [1:0]      taken;
  logic [CP_W-1:0] gathered;

  task automatic push_cp(input logic [CP_W-1:0] cp);
    cp_item_t item;
    item.cp   = cp;
    item.last = 1'b0;
    cp_expected_q.push_back(item);
  endtask

  task automatic close_sequence();
    open_len = SEQ_NONE;
    taken    = 2'd0;
    gathered = '0;
  endtask

  task automatic predict_code_points(input logic [7:0] b);
    int         before_n;
    logic [2:0] next_taken;
    cp_item_t   tail_item;
    before_n = cp_expected_q.size();
    if (open_len != SEQ_NONE && b[7:6] == 2'b10) begin
      gathered   = {gathered[CP_W-7:0], b[5:0]};
      next_taken = {1'b0, taken} + 3'd1;
      taken      = next_taken[1:0];
      if (next_taken >= open_len) begin
        push_cp(gathered);
        close_sequence();
      end
    end else begin
      // broken sequence or end of text: one replacement per held byte
      if (open_len != SEQ_NONE) begin
        repeat (taken) push_cp(REPLACEMENT_CP);
        close_sequence();
      end
      if (b != 8'h00) begin
        casez (b)
          8'b0???????: push_cp({{(CP_W-8){1'b0}}, b});
          8'b110?????: begin
            open_len = SEQ_TWO;
            taken    = 2'd1;
            gathered = {{(CP_W-5){1'b0}}, b[4:0]};
          end
          8'b1110????: begin
            open_len = SEQ_THREE;
            taken    = 2'd1;
            gathered = {{(CP_W-4){1'b0}}, b[3:0]};
          end
          8'b11110???: begin
            open_len = SEQ_FOUR;
            taken    = 2'd1;
            gathered = {{(CP_W-3){1'b0}}, b[2:0]};
          end
          // stray continuation or invalid lead
          default: push_cp(REPLACEMENT_CP);
        endcase
      end
    end
    if (cp_expected_q.size() > before_n) begin
      tail_item      = cp_expected_q.pop_back();
      tail_item.last = 1'b1;
      cp_expected_q.push_back(tail_item);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mismatches = 0;
      close_sequence();
      cp_expected_q.delete();
    end else begin
      // predict before checking so a same-edge result would still find its entry
      if (in_valid && in_ready) predict_code_points(in_byte);
      if (out_valid && out_ready) begin
        if (cp_expected_q.size() == 0) begin
          $error("code_point: expected nothing, actual %h", code_point);
          mismatches++;
        end else begin
          want = cp_expected_q.pop_front();
          if (code_point !== want.cp) begin
            $error("code_point: expected %h, actual %h", want.cp, code_point);
            mismatches++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %b, actual %b", want.last, last_of_run);
            mismatches++;
          end
        end
      end
    end
    awaited <= cp_expected_q.size();
  end

endmodule

/* tb/sv/tb.sv */
// Top of the utf8_stream_decoder testbench: clock, reset, byte stimulus and result stalls.
// Depends on utf8sd_pkg, utf8_stream_decoder and utf8sd_checker.
`timescale 1ns / 100ps
module tb;
  import utf8sd_pkg::*;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic [7:0]      in_byte   = 8'h00;
  logic            out_ready = 1'b0;
  logic            in_ready;
  logic            out_valid;
  logic [CP_W-1:0] code_point;
  logic            last_of_run;
  int              mismatches;
  int              awaited;
  int              bytes_sent = 0;
  bit              calm       = 1'b0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  utf8_stream_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .last_of_run (last_of_run)
  );

  utf8sd_checker chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .last_of_run (last_of_run),
    .mismatches  (mismatches),
    .awaited     (awaited)
  );

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // One piece of text: mostly ASCII and well-formed sequences, some broken ones and noise
  task automatic send_text_unit();
    int         kind;
    int         len;
    int         conts;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      send_byte(8'($urandom_range(1, 127)));
    end else if (kind < 88) begin
      len = $urandom_range(2, 4);
      case (len)
        2:       b = {3'b110, 5'($urandom)};
        3:       b = {4'b1110, 4'($urandom)};
        default: b = {5'b11110, 3'($urandom)};
      endcase
      send_byte(b);
      conts = (kind < 75) ? len - 1 : $urandom_range(0, len - 2);
      repeat (conts) send_byte({2'b10, 6'($urandom)});
      if (kind >= 75) begin
        // breaking byte: anything but a continuation
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        if ($urandom_range(0, 4) == 0) b = 8'h00;
        send_byte(b);
      end
    end else if (kind < 95) begin
      if ($urandom_range(0, 1) == 0) send_byte({2'b10, 6'($urandom)});
      else send_byte({5'b11111, 3'($urandom)});
    end else begin
      send_byte(8'h00);
    end
  endtask

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side stalls
  initial begin
    int run;
    while (rst) @(posedge clk);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
        repeat (run) @(posedge clk);
        if (!calm) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 14)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    logic [7:0] directed_bytes[$] = '{
      8'h00, 8'h41, 8'h7F, 8'h80, 8'hF8, 8'hFF,
      8'hC3, 8'hA9,
      8'hE2, 8'h82, 8'hAC,
      8'hF7, 8'hBF, 8'hBF, 8'hBF,
      8'hF0, 8'h80, 8'h80, 8'h80,
      8'hC0, 8'h41,
      8'hE2, 8'h82, 8'h00,
      8'hF0, 8'h90, 8'h8D, 8'hF8
    };
    bit drained = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    while (bytes_sent < 210) begin
      if (bytes_sent >= 170) calm = 1'b1;
      if (!drained && bytes_sent >= 110) begin
        wait_for_results();
        drained = 1'b1;
      end
      send_text_unit();
    end
    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/utf8sd_pkg.sv
design/utf8sd_decode.sv
design/utf8sd_seq.sv
design/utf8_stream_decoder.sv
tb/sv/utf8sd_checker.sv
tb/sv/tb.sv
